// File: rtl/ihq_pkg.sv
// Package for the indexed min-heap queue: command codes, key width and
// default sizes. It has no dependencies and is used by every module but ihq_ram.
package ihq_pkg;

  localparam int KEY_W        = 32;
  localparam int CMD_W        = 2;
  localparam int CAPACITY_DEF = 1024;
  localparam int MAX_OPS_DEF  = 4096;

  localparam logic [CMD_W-1:0] CMD_PUSH    = 2'd0;
  localparam logic [CMD_W-1:0] CMD_EXTRACT = 2'd1;
  localparam logic [CMD_W-1:0] CMD_DECR    = 2'd2;
  localparam logic [CMD_W-1:0] CMD_UNUSED  = 2'd3;

endpackage

// File: rtl/ihq_cmp.sv
// Shared signed key comparator of the indexed min-heap queue.
// Depends on ihq_pkg for the key width.
module ihq_cmp import ihq_pkg::*; (
  input  logic signed [KEY_W-1:0] a,
  input  logic signed [KEY_W-1:0] b,
  output logic                    lt
);

  // Every ordering decision of the sequencer goes through this one compare.
  assign lt = (a < b);

endmodule

// File: rtl/ihq_ram.sv
// Simple dual-port RAM with one write port and one registered read port.
// Used for the heap store and the slot index table; no dependencies.
module ihq_ram #(
  parameter int DEPTH = 1024,
  parameter int WIDTH = 8
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] waddr,
  input  logic [WIDTH-1:0]         wdata,
  input  logic [$clog2(DEPTH)-1:0] raddr,
  output logic [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata <= mem[raddr];
  end

endmodule

// File: rtl/indexed_min_heap_queue.sv
// Top level of the indexed min-heap queue with decrease-key.
// Depends on ihq_pkg, ihq_cmp and ihq_ram.
// Usage: the input channel carries one command word per handshake: a push of
// in_key_value, an extract-min, or a decrease-key of the push numbered
// in_op_ref down to in_key_value. Every command uses up the next operation
// number, counted from 1, until MAX_OPS are used. Only extract-min produces a
// result word on the output channel: the smallest key and the number of its
// push, or an empty flag with zero fields.
// Timing: one command is worked on at a time by a small sequencer around a
// single key comparator and two single-port-write memories with registered
// reads. A push reads and compares the parent for each heap level it rises,
// then places the entry; an extract reads the root and the last entry, then
// reads both children, picks one and moves it for each level it sinks, then
// places the entry and emits; a decrease-key reads its slot and entry, then rises.
// Reset: after rst_n is released the block walks the slot table once, marking
// every operation number as not queued; in_stall is high during that sweep.
// Stall: the result word sits in an output register. A new command is still
// accepted while it waits; an extract that finishes while the previous
// result is still stalled holds in its last state until the register frees.
module indexed_min_heap_queue import ihq_pkg::*; #(
  parameter int CAPACITY = CAPACITY_DEF,
  parameter int MAX_OPS  = MAX_OPS_DEF,
  localparam int OP_W    = $clog2(MAX_OPS + 1)
) (
  input  logic                    clk,
  input  logic                    rst_n,
  input  logic                    in_valid,
  output logic                    in_stall,
  input  logic [CMD_W-1:0]        in_command,
  input  logic signed [KEY_W-1:0] in_key_value,
  input  logic [OP_W-1:0]         in_op_ref,
  output logic                    out_valid,
  input  logic                    out_stall,
  output logic                    out_is_empty,
  output logic signed [KEY_W-1:0] out_min_value,
  output logic [OP_W-1:0]         out_origin_op
);

  localparam int IDX_W = $clog2(CAPACITY);
  localparam int CNT_W = $clog2(CAPACITY + 1);
  localparam int SA_W  = $clog2(MAX_OPS);
  localparam int HW    = KEY_W + OP_W;
  localparam int SW    = IDX_W + 1;

  typedef enum logic [13:0] {
    S_CLEAR   = 14'b00000000000001,
    S_IDLE    = 14'b00000000000010,
    S_UP_RD   = 14'b00000000000100,
    S_UP_CMP  = 14'b00000000001000,
    S_PLACE   = 14'b00000000010000,
    S_EX_TOP  = 14'b00000000100000,
    S_EX_LAST = 14'b00000001000000,
    S_DN_RDL  = 14'b00000010000000,
    S_DN_RDR  = 14'b00000100000000,
    S_DN_PICK = 14'b00001000000000,
    S_DN_MOVE = 14'b00010000000000,
    S_DK_SLOT = 14'b00100000000000,
    S_DK_CMP  = 14'b01000000000000,
    S_EMIT    = 14'b10000000000000
  } state_t;

  state_t state_r, state_nxt;

  logic [SA_W-1:0]         clr_r, clr_nxt;
  logic [CNT_W-1:0]        count_r, count_nxt;
  logic [OP_W-1:0]         opc_r, opc_nxt;
  logic [IDX_W-1:0]        i_r, i_nxt;
  logic [IDX_W-1:0]        j_r, j_nxt;
  logic signed [KEY_W-1:0] ekey_r, ekey_nxt;
  logic [OP_W-1:0]         eop_r, eop_nxt;
  logic [HW-1:0]           child_r, child_nxt;
  logic [HW-1:0]           lc_r, lc_nxt;
  logic                    rok_r, rok_nxt;
  logic                    ex_r, ex_nxt;
  logic                    empty_r, empty_nxt;
  logic signed [KEY_W-1:0] rkey_r, rkey_nxt;
  logic [OP_W-1:0]         rop_r, rop_nxt;
  logic signed [KEY_W-1:0] dkey_r, dkey_nxt;
  logic                    ov_r, ov_nxt;
  logic                    oe_r, oe_nxt;
  logic signed [KEY_W-1:0] okey_r, okey_nxt;
  logic [OP_W-1:0]         oop_r, oop_nxt;

  // Memory ports.
  logic             h_we, s_we;
  logic [IDX_W-1:0] h_waddr, h_raddr;
  logic [HW-1:0]    h_wdata, h_rdata;
  logic [SA_W-1:0]  s_waddr, s_raddr;
  logic [SW-1:0]    s_wdata, s_rdata;

  // Shared comparator.
  logic signed [KEY_W-1:0] cmp_a, cmp_b;
  logic                    cmp_lt;

  logic signed [KEY_W-1:0] rd_key, lc_key, child_key;
  logic [OP_W-1:0]         rd_op, child_op;
  logic [CNT_W:0]          l_ext, r_ext;
  logic [IDX_W-1:0]        parent;
  logic                    in_acc;

  ihq_ram #(.DEPTH(CAPACITY), .WIDTH(HW)) u_heap (
    .clk(clk), .we(h_we), .waddr(h_waddr), .wdata(h_wdata),
    .raddr(h_raddr), .rdata(h_rdata)
  );

  ihq_ram #(.DEPTH(MAX_OPS), .WIDTH(SW)) u_slot (
    .clk(clk), .we(s_we), .waddr(s_waddr), .wdata(s_wdata),
    .raddr(s_raddr), .rdata(s_rdata)
  );

  ihq_cmp u_cmp (.a(cmp_a), .b(cmp_b), .lt(cmp_lt));

  assign rd_key    = h_rdata[HW-1 -: KEY_W];
  assign rd_op     = h_rdata[OP_W-1:0];
  assign lc_key    = lc_r[HW-1 -: KEY_W];
  assign child_key = child_r[HW-1 -: KEY_W];
  assign child_op  = child_r[OP_W-1:0];
  assign l_ext     = (CNT_W + 1)'({i_r, 1'b1});
  assign r_ext     = l_ext + (CNT_W + 1)'(1);
  assign parent    = IDX_W'((i_r - IDX_W'(1)) >> 1);

  assign in_stall = (state_r != S_IDLE);
  assign in_acc   = in_valid && !in_stall;

  always_comb begin
    state_nxt = state_r;
    clr_nxt   = clr_r;
    count_nxt = count_r;
    opc_nxt   = opc_r;
    i_nxt     = i_r;
    j_nxt     = j_r;
    ekey_nxt  = ekey_r;
    eop_nxt   = eop_r;
    child_nxt = child_r;
    lc_nxt    = lc_r;
    rok_nxt   = rok_r;
    ex_nxt    = ex_r;
    empty_nxt = empty_r;
    rkey_nxt  = rkey_r;
    rop_nxt   = rop_r;
    dkey_nxt  = dkey_r;
    ov_nxt    = ov_r && out_stall;
    oe_nxt    = oe_r;
    okey_nxt  = okey_r;
    oop_nxt   = oop_r;
    h_we      = 1'b0;
    h_waddr   = i_r;
    h_wdata   = {ekey_r, eop_r};
    h_raddr   = '0;
    s_we      = 1'b0;
    s_waddr   = SA_W'(eop_r - OP_W'(1));
    s_wdata   = {1'b1, i_r};
    s_raddr   = SA_W'(in_op_ref - OP_W'(1));
    cmp_a     = ekey_r;
    cmp_b     = rd_key;

    case (state_r)
      S_CLEAR: begin
        s_we    = 1'b1;
        s_waddr = clr_r;
        s_wdata = '0;
        clr_nxt = clr_r + SA_W'(1);
        if (clr_r == SA_W'(MAX_OPS - 1)) begin
          state_nxt = S_IDLE;
        end
      end
      S_IDLE: begin
        if (in_acc) begin
          logic [OP_W-1:0] num;
          num = '0;
          if (opc_r < OP_W'(MAX_OPS)) begin
            num     = opc_r + OP_W'(1);
            opc_nxt = num;
          end
          ex_nxt   = 1'b0;
          dkey_nxt = in_key_value;
          case (in_command)
            CMD_PUSH: begin
              if (num != '0 && count_r < CNT_W'(CAPACITY)) begin
                i_nxt     = IDX_W'(count_r);
                count_nxt = count_r + CNT_W'(1);
                ekey_nxt  = in_key_value;
                eop_nxt   = num;
                state_nxt = S_UP_RD;
              end
            end
            CMD_EXTRACT: begin
              ex_nxt = 1'b1;
              if (count_r == '0) begin
                empty_nxt = 1'b1;
                rkey_nxt  = '0;
                rop_nxt   = '0;
                state_nxt = S_EMIT;
              end else begin
                empty_nxt = 1'b0;
                h_raddr   = '0;
                state_nxt = S_EX_TOP;
              end
            end
            CMD_DECR: begin
              if (in_op_ref != '0 && in_op_ref <= OP_W'(MAX_OPS)) begin
                state_nxt = S_DK_SLOT;
              end
            end
            default: begin
            end
          endcase
        end
      end
      S_UP_RD: begin
        h_raddr = parent;
        if (i_r == '0) begin
          state_nxt = S_PLACE;
        end else begin
          state_nxt = S_UP_CMP;
        end
      end
      S_UP_CMP: begin
        cmp_a = ekey_r;
        cmp_b = rd_key;
        if (cmp_lt) begin
          h_we      = 1'b1;
          h_wdata   = h_rdata;
          s_we      = 1'b1;
          s_waddr   = SA_W'(rd_op - OP_W'(1));
          i_nxt     = parent;
          state_nxt = S_UP_RD;
        end else begin
          state_nxt = S_PLACE;
        end
      end
      S_PLACE: begin
        h_we = 1'b1;
        s_we = 1'b1;
        state_nxt = ex_r ? S_EMIT : S_IDLE;
      end
      S_EX_TOP: begin
        rkey_nxt  = rd_key;
        rop_nxt   = rd_op;
        s_we      = 1'b1;
        s_waddr   = SA_W'(rd_op - OP_W'(1));
        s_wdata   = '0;
        count_nxt = count_r - CNT_W'(1);
        h_raddr   = IDX_W'(count_r - CNT_W'(1));
        if (count_r == CNT_W'(1)) begin
          state_nxt = S_EMIT;
        end else begin
          state_nxt = S_EX_LAST;
        end
      end
      S_EX_LAST: begin
        ekey_nxt  = rd_key;
        eop_nxt   = rd_op;
        i_nxt     = '0;
        state_nxt = S_DN_RDL;
      end
      S_DN_RDL: begin
        h_raddr = IDX_W'(l_ext);
        rok_nxt = (r_ext < (CNT_W + 1)'(count_r));
        if (l_ext < (CNT_W + 1)'(count_r)) begin
          state_nxt = S_DN_RDR;
        end else begin
          state_nxt = S_PLACE;
        end
      end
      S_DN_RDR: begin
        lc_nxt    = h_rdata;
        h_raddr   = IDX_W'(r_ext);
        state_nxt = S_DN_PICK;
      end
      S_DN_PICK: begin
        cmp_a = rd_key;
        cmp_b = lc_key;
        if (rok_r && cmp_lt) begin
          child_nxt = h_rdata;
          j_nxt     = IDX_W'(r_ext);
        end else begin
          child_nxt = lc_r;
          j_nxt     = IDX_W'(l_ext);
        end
        state_nxt = S_DN_MOVE;
      end
      S_DN_MOVE: begin
        cmp_a = child_key;
        cmp_b = ekey_r;
        if (cmp_lt) begin
          h_we      = 1'b1;
          h_wdata   = child_r;
          s_we      = 1'b1;
          s_waddr   = SA_W'(child_op - OP_W'(1));
          i_nxt     = j_r;
          state_nxt = S_DN_RDL;
        end else begin
          state_nxt = S_PLACE;
        end
      end
      S_DK_SLOT: begin
        h_raddr = s_rdata[IDX_W-1:0];
        i_nxt   = s_rdata[IDX_W-1:0];
        if (s_rdata[SW-1] && CNT_W'(s_rdata[IDX_W-1:0]) < count_r) begin
          state_nxt = S_DK_CMP;
        end else begin
          state_nxt = S_IDLE;
        end
      end
      S_DK_CMP: begin
        // Apply only when the new key is not above the stored one.
        cmp_a = rd_key;
        cmp_b = dkey_r;
        if (!cmp_lt) begin
          ekey_nxt  = dkey_r;
          eop_nxt   = rd_op;
          state_nxt = S_UP_RD;
        end else begin
          state_nxt = S_IDLE;
        end
      end
      S_EMIT: begin
        if (!ov_r || !out_stall) begin
          ov_nxt    = 1'b1;
          oe_nxt    = empty_r;
          okey_nxt  = rkey_r;
          oop_nxt   = rop_r;
          state_nxt = S_IDLE;
        end
      end
      default: begin
        state_nxt = S_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= S_CLEAR;
      clr_r   <= '0;
      count_r <= '0;
      opc_r   <= '0;
      ov_r    <= 1'b0;
    end else begin
      state_r <= state_nxt;
      clr_r   <= clr_nxt;
      count_r <= count_nxt;
      opc_r   <= opc_nxt;
      ov_r    <= ov_nxt;
    end
  end

  always_ff @(posedge clk) begin
    i_r     <= i_nxt;
    j_r     <= j_nxt;
    ekey_r  <= ekey_nxt;
    eop_r   <= eop_nxt;
    child_r <= child_nxt;
    lc_r    <= lc_nxt;
    rok_r   <= rok_nxt;
    ex_r    <= ex_nxt;
    empty_r <= empty_nxt;
    rkey_r  <= rkey_nxt;
    rop_r   <= rop_nxt;
    dkey_r  <= dkey_nxt;
    oe_r    <= oe_nxt;
    okey_r  <= okey_nxt;
    oop_r   <= oop_nxt;
  end

  assign out_valid     = ov_r;
  assign out_is_empty  = oe_r;
  assign out_min_value = okey_r;
  assign out_origin_op = oop_r;

endmodule

// File: rtl/ihq_chk.sv
// Port-level checker for the indexed min-heap queue, bound to the top level.
// Depends on ihq_pkg for widths.
module ihq_chk import ihq_pkg::*; #(
  parameter int OPW = $clog2(MAX_OPS_DEF + 1)
) (
  input logic                    clk,
  input logic                    rst_n,
  input logic                    in_stall,
  input logic                    out_valid,
  input logic                    out_stall,
  input logic                    out_is_empty,
  input logic signed [KEY_W-1:0] out_min_value,
  input logic [OPW-1:0]          out_origin_op
);

  // The slot table sweep keeps the input closed right after reset.
  a_clear_after_reset: assert property (@(posedge clk) !rst_n |=> in_stall)
    else $error("input open during the post-reset sweep");

  a_empty_zero: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_is_empty |-> out_min_value == '0 && out_origin_op == '0)
    else $error("empty result word carries nonzero fields");

  a_origin_nonzero: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && !out_is_empty |-> out_origin_op != '0)
    else $error("extracted entry has no push number");

  a_hold: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_stall |=> out_valid && $stable(out_min_value))
    else $error("stalled result word changed");

endmodule

bind indexed_min_heap_queue ihq_chk #(.OPW(OP_W)) u_ihq_chk (
  .clk(clk), .rst_n(rst_n), .in_stall(in_stall), .out_valid(out_valid),
  .out_stall(out_stall), .out_is_empty(out_is_empty),
  .out_min_value(out_min_value), .out_origin_op(out_origin_op)
);

// File: dv/tb_indexed_min_heap_queue.sv
// Self-checking testbench for indexed_min_heap_queue: a clocked driver and monitor,
// with a heap predictor that keeps its own copy of the queue state.
// Depends on ihq_pkg and the indexed_min_heap_queue RTL only.
module tb_indexed_min_heap_queue;
  import ihq_pkg::*;
  timeunit 1ns;
  timeprecision 1ps;

  localparam int OP_W      = $clog2(MAX_OPS_DEF + 1);
  localparam int IDLE_MAX  = 20000;  // cycles with no handshake before we give up
  localparam int LONG_HOLD = 3000;   // one long receiver stall, to back up the block

  typedef struct {
    logic [CMD_W-1:0]        cmd;
    logic signed [KEY_W-1:0] key;
    logic [OP_W-1:0]         op_ref;
    bit                      drain;  // marker word: wait until all results are back
  } cmd_word_t;

  typedef struct {
    logic                    is_empty;
    logic signed [KEY_W-1:0] min_value;
    logic [OP_W-1:0]         origin_op;
  } min_result_t;

  logic                    clk;
  logic                    rst_n;
  logic                    in_valid;
  logic                    in_stall;
  logic [CMD_W-1:0]        in_command;
  logic signed [KEY_W-1:0] in_key_value;
  logic [OP_W-1:0]         in_op_ref;
  logic                    out_valid;
  logic                    out_stall;
  logic                    out_is_empty;
  logic signed [KEY_W-1:0] out_min_value;
  logic [OP_W-1:0]         out_origin_op;

  indexed_min_heap_queue i_dut (
    .clk           (clk),
    .rst_n         (rst_n),
    .in_valid      (in_valid),
    .in_stall      (in_stall),
    .in_command    (in_command),
    .in_key_value  (in_key_value),
    .in_op_ref     (in_op_ref),
    .out_valid     (out_valid),
    .out_stall     (out_stall),
    .out_is_empty  (out_is_empty),
    .out_min_value (out_min_value),
    .out_origin_op (out_origin_op)
  );

  // Shadow copy of the heap that the predictor works on.
  logic signed [KEY_W-1:0] heap_keys [CAPACITY_DEF];
  int                      heap_ops  [CAPACITY_DEF];
  int                      slot_of   [MAX_OPS_DEF];
  bit                      queued    [MAX_OPS_DEF];
  int                      heap_size;
  int                      ops_used;

  cmd_word_t   pending_words[$];
  min_result_t due_results[$];
  int          pushed_ops[$];  // op numbers the generator believes were pushed
  int          gen_op;         // generator's running operation number
  int          n_offered;
  int          n_taken;
  int          n_errors;
  int          idle_cycles;
  int          hold_left;
  bit          hold_done;
  logic        calm;           // stretch of the run with no random idling

  assign calm = (n_taken >= 500) && (n_taken < 800);

  initial begin
    clk = 1'b0;
    forever #6 clk = ~clk;
  end

  task automatic report_mismatch(input string what);
    n_errors++;
    $display("MISMATCH at %0t: %s", $realtime, what);
  endtask

  // ---------------------------------------------------------------------------
  // Predictor: an array-based binary min-heap with an index from operation
  // number to heap slot, so that a decrease-key can find its entry.
  // ---------------------------------------------------------------------------
  function automatic void place_entry(int i, logic signed [KEY_W-1:0] k, int op);
    heap_keys[i] = k;
    heap_ops[i]  = op;
    slot_of[op-1] = i;
  endfunction

  function automatic void swap_slots(int a, int b);
    logic signed [KEY_W-1:0] ka;
    int oa;
    ka = heap_keys[a];
    oa = heap_ops[a];
    place_entry(a, heap_keys[b], heap_ops[b]);
    place_entry(b, ka, oa);
  endfunction

  // Ties stay put: an entry only rises past a strictly larger parent.
  function automatic void sift_up(int i);
    while (i > 0 && heap_keys[i] < heap_keys[(i-1)/2]) begin
      swap_slots(i, (i-1)/2);
      i = (i-1)/2;
    end
  endfunction

  // The left child wins unless the right one is strictly smaller.
  function automatic void sift_down(int i);
    int j;
    while (2*i + 1 < heap_size) begin
      j = 2*i + 1;
      if (j + 1 < heap_size && heap_keys[j+1] < heap_keys[j]) j = j + 1;
      if (heap_keys[i] <= heap_keys[j]) break;
      swap_slots(i, j);
      i = j;
    end
  endfunction

  function automatic void predict_heap(logic [CMD_W-1:0] cmd, logic signed [KEY_W-1:0] k,
                                       logic [OP_W-1:0] op_ref);
    int          num;
    int          s;
    min_result_t r;
    num = 0;
    // The operation counter saturates; after that pushes are dropped.
    if (ops_used < MAX_OPS_DEF) begin
      ops_used++;
      num = ops_used;
    end
    case (cmd)
      CMD_PUSH: begin
        if (num != 0 && heap_size < CAPACITY_DEF) begin
          heap_size++;
          place_entry(heap_size - 1, k, num);
          queued[num-1] = 1'b1;
          sift_up(heap_size - 1);
        end
      end
      CMD_EXTRACT: begin
        if (heap_size == 0) begin
          r.is_empty  = 1'b1;
          r.min_value = '0;
          r.origin_op = '0;
        end else begin
          r.is_empty  = 1'b0;
          r.min_value = heap_keys[0];
          r.origin_op = OP_W'(heap_ops[0]);
          queued[heap_ops[0]-1] = 1'b0;
          heap_size--;
          if (heap_size > 0) begin
            place_entry(0, heap_keys[heap_size], heap_ops[heap_size]);
            sift_down(0);
          end
        end
        due_results.push_back(r);
      end
      CMD_DECR: begin
        // Stale references and increases are ignored.
        if (op_ref >= 1 && op_ref <= MAX_OPS_DEF && queued[op_ref-1]) begin
          s = slot_of[op_ref-1];
          if (s < heap_size && k <= heap_keys[s]) begin
            heap_keys[s] = k;
            sift_up(s);
          end
        end
      end
      default: ;  // the unused code only burns an operation number
    endcase
  endfunction

  // ---------------------------------------------------------------------------
  // Driver: presents one word at a time from pending_words and holds it until
  // the handshake happens. A drain marker parks the sender until the block
  // has returned every result it owes.
  // ---------------------------------------------------------------------------
  always @(negedge clk) begin
    if (!rst_n) begin
      in_valid <= 1'b0;
    end else if (in_valid && n_taken != n_offered) begin
      // Word not taken yet: keep it steady.
    end else begin
      while (pending_words.size() > 0 && pending_words[0].drain &&
             due_results.size() == 0 && n_taken == n_offered)
        void'(pending_words.pop_front());
      if (pending_words.size() > 0 && !pending_words[0].drain &&
          (calm || $urandom_range(0, 99) >= 17)) begin
        in_command   <= pending_words[0].cmd;
        in_key_value <= pending_words[0].key;
        in_op_ref    <= pending_words[0].op_ref;
        in_valid     <= 1'b1;
        n_offered++;
        void'(pending_words.pop_front());
      end else begin
        in_valid <= 1'b0;
      end
    end
  end

  // The receiver stalls at random, and once for a long stretch so that the
  // result register backs up and the block has to stall its input.
  always @(negedge clk) begin
    if (hold_left > 0) begin
      hold_left--;
      out_stall <= 1'b1;
    end else if (!hold_done && n_taken >= 200) begin
      hold_done = 1'b1;
      hold_left = LONG_HOLD;
      out_stall <= 1'b1;
    end else begin
      out_stall <= !calm && ($urandom_range(0, 99) < 17);
    end
  end

  // ---------------------------------------------------------------------------
  // Monitor: feeds accepted command words to the predictor and compares each
  // accepted result word with the oldest expectation. It also runs the
  // watchdog on cycles without any handshake.
  // ---------------------------------------------------------------------------
  always @(posedge clk) begin
    min_result_t want;
    if (rst_n) begin
      idle_cycles++;
      if (in_valid && !in_stall) begin
        predict_heap(in_command, in_key_value, in_op_ref);
        n_taken++;
        idle_cycles = 0;
      end
      if (out_valid && !out_stall) begin
        idle_cycles = 0;
        if (due_results.size() == 0) begin
          report_mismatch($sformatf("unexpected result word empty=%0b key=%0d op=%0d",
                                    out_is_empty, out_min_value, out_origin_op));
        end else begin
          want = due_results.pop_front();
          if (out_is_empty !== want.is_empty)
            report_mismatch($sformatf("is_empty %0b, predicted %0b",
                                      out_is_empty, want.is_empty));
          if (out_min_value !== want.min_value)
            report_mismatch($sformatf("min_value %0d, predicted %0d",
                                      out_min_value, want.min_value));
          if (out_origin_op !== want.origin_op)
            report_mismatch($sformatf("origin_op %0d, predicted %0d",
                                      out_origin_op, want.origin_op));
        end
      end
      if (idle_cycles >= IDLE_MAX) begin
        $display("*** FAILED ***");
        $finish;
      end
    end
  end

  // Queues one command word and tracks the operation number it will use.
  task automatic add_word(input logic [CMD_W-1:0] cmd, input logic signed [KEY_W-1:0] k,
                          input logic [OP_W-1:0] op_ref);
    cmd_word_t w;
    w.cmd    = cmd;
    w.key    = k;
    w.op_ref = op_ref;
    w.drain  = 1'b0;
    pending_words.push_back(w);
    if (gen_op < MAX_OPS_DEF) begin
      gen_op++;
      if (cmd == CMD_PUSH) pushed_ops.push_back(gen_op);
    end
  endtask

  task automatic add_drain();
    cmd_word_t w;
    w.cmd    = CMD_PUSH;
    w.key    = '0;
    w.op_ref = '0;
    w.drain  = 1'b1;
    pending_words.push_back(w);
  endtask

  // A key that is either fully random or drawn from a narrow band, the latter
  // so that ties and successful decreases show up often.
  function automatic logic signed [KEY_W-1:0] pick_key();
    if ($urandom_range(0, 1) == 0) return $urandom;
    return $signed($urandom_range(0, 60)) - 30;
  endfunction

  // Mostly names a push the generator issued earlier; sometimes any 13-bit value.
  function automatic logic [OP_W-1:0] pick_ref();
    if (pushed_ops.size() == 0 || $urandom_range(0, 99) < 20) return OP_W'($urandom);
    return OP_W'(pushed_ops[$urandom_range(0, pushed_ops.size() - 1)]);
  endfunction

  task automatic add_random_word();
    int roll;
    roll = $urandom_range(0, 99);
    if (roll < 45)      add_word(CMD_PUSH, pick_key(), OP_W'($urandom));
    else if (roll < 75) add_word(CMD_EXTRACT, $urandom, OP_W'($urandom));
    else if (roll < 95) add_word(CMD_DECR, pick_key() - 20, pick_ref());
    else                add_word(CMD_UNUSED, $urandom, OP_W'($urandom));
  endtask

  initial begin
    rst_n        = 1'b0;
    in_valid     = 1'b0;
    in_command   = CMD_PUSH;
    in_key_value = '0;
    in_op_ref    = '0;
    out_stall    = 1'b0;
    heap_size    = 0;
    ops_used     = 0;
    gen_op       = 0;
    n_offered    = 0;
    n_taken      = 0;
    n_errors     = 0;
    idle_cycles  = 0;
    hold_left    = 0;
    hold_done    = 1'b0;
    foreach (queued[i]) queued[i] = 1'b0;

    // Directed opening: empty extract, extreme keys, ties, every kind of
    // ignored decrease-key, a real decrease, and the unused command code.
    add_word(CMD_EXTRACT, 0, 0);                      // op 1, queue empty
    add_word(CMD_PUSH, 32'sh7fffffff, '1);            // op 2
    add_word(CMD_PUSH, 32'sh80000000, '0);            // op 3
    add_word(CMD_PUSH, 0, 0);                         // op 4
    add_word(CMD_PUSH, 0, 0);                         // op 5, tie with op 4
    add_word(CMD_EXTRACT, 0, 0);                      // takes op 3
    add_word(CMD_DECR, -5, 3);                        // already extracted
    add_word(CMD_DECR, 100, 2);                       // a real decrease
    add_word(CMD_DECR, 50, 4);                        // increase, ignored
    add_word(CMD_DECR, 0, 5);                         // equal key
    add_word(CMD_DECR, -1, 0);                        // reference zero
    add_word(CMD_DECR, -1, OP_W'(MAX_OPS_DEF + 1));   // beyond the last number
    add_word(CMD_DECR, -1, '1);                       // all ones
    add_word(CMD_DECR, -1, 1);                        // names an extract
    add_word(CMD_UNUSED, '1, '1);                     // unused code
    repeat (4) add_word(CMD_EXTRACT, 0, 0);           // drain, last one empty
    add_word(CMD_PUSH, -7, 0);
    add_word(CMD_DECR, 32'sh80000000, OP_W'(gen_op)); // down to the minimum
    add_word(CMD_EXTRACT, 0, 0);
    add_drain();

    // Random mix, with one pause of the sender half way.
    for (int n = 0; n < 870; n++) begin
      if (n == 435) add_drain();
      add_random_word();
    end
    add_drain();

    repeat (9) @(posedge clk);
    @(negedge clk);
    rst_n = 1'b1;

    while (pending_words.size() > 0 || n_taken != n_offered || due_results.size() > 0)
      @(posedge clk);
    repeat (200) @(posedge clk);
    if (n_errors == 0) begin
      $display("*** PASSED ***");
    end else begin
      $display("*** FAILED ***");
    end
    $finish;
  end

endmodule
